// ===== rtl/core/u8d_pkg.sv =====
package u8d_pkg;

    // decoded character values
    localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;

    // shortest-form lower bounds per sequence length
    localparam logic [20:0] MIN_LEN2   = 21'h000080;
    localparam logic [20:0] MIN_LEN3   = 21'h000800;
    localparam logic [20:0] MIN_LEN4   = 21'h010000;

    // byte classes
    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_CODE  = 8'h80;
    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE = 8'hF0;

    // sequence lengths
    localparam logic [2:0]  LEN_NONE   = 3'd0;
    localparam logic [2:0]  LEN_1      = 3'd1;
    localparam logic [2:0]  LEN_2      = 3'd2;
    localparam logic [2:0]  LEN_3      = 3'd3;
    localparam logic [2:0]  LEN_4      = 3'd4;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one job: n_flush replacements at base, base+1, ..., then optionally
    // the main result at base+n_flush
    typedef struct packed {
        logic [1:0]  n_flush;
        logic        has_main;
        logic [20:0] cp;
        logic [2:0]  len;
        logic        repl;
        logic        wf;
        logic        eot;
    } t_job;

endpackage

// ===== rtl/core/u8d_front.sv =====
module u8d_front #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [7:0]              i_byte,
    input  logic                    i_eot,
    output logic                    o_ready,
    input  logic                    i_q_ready,
    output logic                    o_push,
    output u8d_pkg::t_job           o_job,
    output logic [OFFSET_WIDTH-1:0] o_base
);

    logic [20:0]             r_pv,   n_pv;
    logic [2:0]              r_exp,  n_exp;
    logic [1:0]              r_bc,   n_bc;
    logic [OFFSET_WIDTH-1:0] r_lead, n_lead;
    logic [OFFSET_WIDTH-1:0] r_next, n_next;

    logic                    accept;
    logic                    cont;
    logic                    pending;
    logic [2:0]              bc_inc;
    logic [20:0]             pv_ext;
    logic [20:0]             least;
    logic                    scalar_ok;
    logic [2:0]              lead_len;
    logic [20:0]             lead_bits;
    u8d_pkg::t_job           job;
    logic [OFFSET_WIDTH-1:0] base;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign cont    = (i_byte & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_CODE;
    assign pending = r_exp != u8d_pkg::LEN_NONE;
    assign bc_inc  = {1'b0, r_bc} + 3'd1;
    assign pv_ext  = {r_pv[14:0], i_byte[5:0]};

    always_comb begin
        unique case (r_exp)
            u8d_pkg::LEN_2: least = u8d_pkg::MIN_LEN2;
            u8d_pkg::LEN_3: least = u8d_pkg::MIN_LEN3;
            default:        least = u8d_pkg::MIN_LEN4;
        endcase
    end

    assign scalar_ok = (pv_ext <= u8d_pkg::MAX_SCALAR) &&
                       !((pv_ext >= u8d_pkg::SURR_LO) && (pv_ext <= u8d_pkg::SURR_HI));

    // lead byte class
    always_comb begin
        lead_len  = u8d_pkg::LEN_NONE;
        lead_bits = '0;
        if ((i_byte & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_CODE) begin
            lead_len  = u8d_pkg::LEN_2;
            lead_bits = {16'd0, i_byte[4:0]};
        end else if ((i_byte & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_CODE) begin
            lead_len  = u8d_pkg::LEN_3;
            lead_bits = {17'd0, i_byte[3:0]};
        end else if ((i_byte & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_CODE) begin
            lead_len  = u8d_pkg::LEN_4;
            lead_bits = {18'd0, i_byte[2:0]};
        end
    end

    always_comb begin
        n_pv     = r_pv;
        n_exp    = r_exp;
        n_bc     = r_bc;
        n_lead   = r_lead;
        n_next   = r_next + OFFSET_WIDTH'(1);
        job      = '0;
        job.eot  = i_eot;
        base     = r_lead;

        if (pending && cont) begin
            if (bc_inc >= r_exp) begin
                // sequence complete
                job.has_main = 1'b1;
                job.len      = r_exp;
                job.repl     = !scalar_ok;
                job.cp       = scalar_ok ? pv_ext : u8d_pkg::REPL_CHAR;
                job.wf       = scalar_ok && (pv_ext >= least);
                n_exp        = u8d_pkg::LEN_NONE;
                n_bc         = '0;
                n_pv         = '0;
            end else begin
                n_pv = pv_ext;
                n_bc = bc_inc[1:0];
                if (i_eot) begin
                    job.n_flush = bc_inc[1:0];
                end
            end
        end else begin
            // no open sequence, or a broken one: replay any collected bytes, then treat as lead
            job.n_flush = pending ? r_bc : 2'd0;
            base        = pending ? r_lead : r_next;
            n_exp       = u8d_pkg::LEN_NONE;
            n_bc        = '0;
            n_pv        = '0;
            job.has_main = 1'b1;
            job.len      = u8d_pkg::LEN_1;
            if (!i_byte[7]) begin
                job.cp = {13'd0, i_byte};
                job.wf = 1'b1;
            end else if (lead_len != u8d_pkg::LEN_NONE && !i_eot) begin
                job.has_main = 1'b0;
                n_exp        = lead_len;
                n_bc         = 2'd1;
                n_pv         = lead_bits;
                n_lead       = r_next;
            end else begin
                // bad lead, or a lead cut off by end of text
                job.cp   = u8d_pkg::REPL_CHAR;
                job.repl = 1'b1;
            end
        end

        if (i_eot) begin
            n_exp  = u8d_pkg::LEN_NONE;
            n_bc   = '0;
            n_pv   = '0;
            n_lead = '0;
            n_next = '0;
        end
    end

    assign o_job  = job;
    assign o_base = base;
    assign o_push = accept && ((job.n_flush != 2'd0) || job.has_main);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= '0;
            r_exp  <= u8d_pkg::LEN_NONE;
            r_bc   <= '0;
            r_lead <= '0;
            r_next <= '0;
        end else if (accept) begin
            r_pv   <= n_pv;
            r_exp  <= n_exp;
            r_bc   <= n_bc;
            r_lead <= n_lead;
            r_next <= n_next;
        end
    end

endmodule

// ===== rtl/core/u8d_queue.sv =====
module u8d_queue #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  u8d_pkg::t_job           i_job,
    input  logic [OFFSET_WIDTH-1:0] i_base,
    output logic                    o_ready,
    input  logic                    i_pop,
    output logic                    o_valid,
    output u8d_pkg::t_job           o_job,
    output logic [OFFSET_WIDTH-1:0] o_base
);

    u8d_pkg::t_job           r_job  [u8d_pkg::QDEPTH];
    logic [OFFSET_WIDTH-1:0] r_base [u8d_pkg::QDEPTH];
    logic [u8d_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [u8d_pkg::QPTR_W:0]   r_cnt, n_cnt;

    assign o_ready = r_cnt != (u8d_pkg::QPTR_W+1)'(u8d_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_job[r_rd];
    assign o_base  = r_base[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wr]  <= i_job;
            r_base[r_wr] <= i_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/u8d_back.sv =====
module u8d_back #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  u8d_pkg::t_job           i_job,
    input  logic [OFFSET_WIDTH-1:0] i_base,
    output logic                    o_pop,
    input  logic                    i_ready,
    output logic                    o_valid,
    output logic [20:0]             o_cp,
    output logic [31:0]             o_ofs,
    output logic [2:0]              o_len,
    output logic                    o_repl,
    output logic                    o_wf,
    output logic                    o_all,
    output logic                    o_last
);

    logic [1:0]              r_idx;
    logic                    r_flag;
    logic                    r_ov;
    logic [20:0]             r_cp;
    logic [31:0]             r_ofs;
    logic [2:0]              r_len;
    logic                    r_repl;
    logic                    r_wf;
    logic                    r_all;
    logic                    r_last;

    logic                    load;
    logic                    last;
    logic                    is_main;
    logic                    wf;
    logic [OFFSET_WIDTH-1:0] ofs;

    assign load    = i_valid && (!r_ov || i_ready);
    assign last    = ({1'b0, r_idx} + 3'd1) ==
                     ({1'b0, i_job.n_flush} + {2'd0, i_job.has_main});
    assign is_main = i_job.has_main && (r_idx == i_job.n_flush);
    assign wf      = is_main && i_job.wf;
    assign ofs     = i_base + OFFSET_WIDTH'(r_idx);
    assign o_pop   = load && last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= is_main ? i_job.cp   : u8d_pkg::REPL_CHAR;
            r_len  <= is_main ? i_job.len  : u8d_pkg::LEN_1;
            r_repl <= is_main ? i_job.repl : 1'b1;
            r_wf   <= wf;
            r_all  <= r_flag && wf;
            r_ofs  <= 32'(ofs);
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_idx  <= '0;
            r_flag <= 1'b1;
        end else begin
            if (load) begin
                r_ov   <= 1'b1;
                r_idx  <= last ? 2'd0 : r_idx + 2'd1;
                r_flag <= (last && i_job.eot) ? 1'b1 : (r_flag && wf);
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_cp    = r_cp;
    assign o_ofs   = r_ofs;
    assign o_len   = r_len;
    assign o_repl  = r_repl;
    assign o_wf    = r_wf;
    assign o_all   = r_all;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// Streaming UTF-8 decoder with U+FFFD replacement. One byte enters per word
// on the slave side (tlast marks end of text); decoded code points leave on
// the master side with the offset of their first byte, their length and
// validity flags. Throughput is one byte per cycle while each byte yields
// at most one result and the master side is ready; a byte that yields n
// results (a broken sequence replaying up to three collected bytes, plus
// its own result) sends them one after another, as the single output
// register issues one result per cycle while the master side is ready. A
// four-entry job queue between the decoding front end and the output
// sequencer absorbs such bursts, so the input keeps flowing until the queue
// fills. Results pass through the job queue and the output register. Offsets
// count in OFFSET_WIDTH bits and wrap there; end of text zeroes them and
// sets the all-valid flag again. No clearing pass after reset.
module utf8_stream_decoder #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,   // end_of_text
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [20:0] code_point, [52:21] byte_offset,
                                          // [55:53] byte_length
    output logic [2:0]  o_m_axis_tuser,   // [0] replaced, [1] well_formed,
                                          // [2] all_valid_so_far
    output logic        o_m_axis_tlast    // last_of_run
);

    logic                    push;
    u8d_pkg::t_job           f_job;
    logic [OFFSET_WIDTH-1:0] f_base;
    logic                    q_ready;
    logic                    q_valid;
    logic                    pop;
    u8d_pkg::t_job           q_job;
    logic [OFFSET_WIDTH-1:0] q_base;

    logic [20:0] cp;
    logic [31:0] ofs;
    logic [2:0]  len;
    logic        repl;
    logic        wf;
    logic        all_ok;

    // front: decode state, one byte per word, builds a result job
    u8d_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata),
        .i_eot     (i_s_axis_tlast),
        .o_ready   (o_s_axis_tready),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (f_job),
        .o_base    (f_base)
    );

    // jobs waiting for the sequencer
    u8d_queue #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_base  (f_base),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_base  (q_base)
    );

    // back: expands each job into results, keeps the all-valid flag
    u8d_back #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .i_base  (q_base),
        .o_pop   (pop),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_cp    (cp),
        .o_ofs   (ofs),
        .o_len   (len),
        .o_repl  (repl),
        .o_wf    (wf),
        .o_all   (all_ok),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {len, ofs, cp};
    assign o_m_axis_tuser = {all_ok, wf, repl};

endmodule

// ===== rtl/core/u8d_checker.sv =====
module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // replacement carries U+FFFD and is never well formed
    a_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[20:0] == u8d_pkg::REPL_CHAR && !o_m_axis_tuser[1])
        else $error("bad replacement result");

    // running flag cannot be set on a malformed result; length 1..4
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (!o_m_axis_tuser[2] || o_m_axis_tuser[1]) &&
            o_m_axis_tdata[55:53] != 3'd0 && o_m_axis_tdata[55:53] <= 3'd4)
        else $error("inconsistent flags or length");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);
